FILE: src/svrgb_pkg.sv
// Shared types and constants for the slope vector to RGB encoder.
package svrgb_pkg;

	localparam int unsigned IN_W    = 24;
	localparam int unsigned SQ_W    = 48;
	localparam int unsigned LEN_W   = 24;
	localparam int unsigned REM_W   = 28;
	localparam int unsigned DIVD_W  = 33;
	localparam int unsigned DIVS_W  = 25;
	localparam int unsigned QUO_W   = 8;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
	} vec_t;

	typedef struct packed {
		byte_t blue;
		logic  too_short;
	} tag_t;

endpackage

FILE: src/svrgb_in_if.sv
// Input channel: one slope vector per request.
interface svrgb_in_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] slope_x;
	logic signed [23:0] slope_y;

	modport source(output valid, slope_x, slope_y, input ready);
	modport sink(input valid, slope_x, slope_y, output ready);
endinterface

FILE: src/svrgb_out_if.sv
// Output channel: one encoded pixel per request.
interface svrgb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       too_short;

	modport source(output valid, red, green, blue, too_short, input ready);
	modport sink(input valid, red, green, blue, too_short, output ready);
endinterface

FILE: src/svrgb_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module svrgb_sqrt
	import svrgb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_in,
	input  logic [SQ_W-1:0]  rad_in,
	input  vec_t             vec_in,
	output logic             valid_out,
	output logic [LEN_W-1:0] root_out,
	output vec_t             vec_out
);

	logic             v_s    [0:LEN_W];
	logic [SQ_W-1:0]  rad_s  [0:LEN_W];
	logic [REM_W-1:0] rem_s  [0:LEN_W];
	logic [LEN_W-1:0] root_s [0:LEN_W];
	vec_t             vec_s  [0:LEN_W];

	assign v_s[0]    = valid_in;
	assign rad_s[0]  = rad_in;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign vec_s[0]  = vec_in;

	for (genvar i = 0; i < LEN_W; i++) begin : g_step
		logic [REM_W-1:0] rem_c;
		logic [REM_W-1:0] trial;
		logic             take;

		always_comb begin
			rem_c = {rem_s[i][REM_W-3:0], rad_s[i][SQ_W-1 -: 2]};
			trial = {{(REM_W-LEN_W-2){1'b0}}, root_s[i], 2'b01};
			take  = (rem_c >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i+1]  <= {rad_s[i][SQ_W-3:0], 2'b00};
				rem_s[i+1]  <= take ? rem_c - trial : rem_c;
				root_s[i+1] <= {root_s[i][LEN_W-2:0], take};
				vec_s[i+1]  <= vec_s[i];
			end
		end
	end

	assign valid_out = v_s[LEN_W];
	assign root_out  = root_s[LEN_W];
	assign vec_out   = vec_s[LEN_W];

`ifndef NO_ASSERTIONS
	// remainder of a finished root never exceeds twice the root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[LEN_W] |-> rem_s[LEN_W] <= {{(REM_W-LEN_W-1){1'b0}}, root_s[LEN_W], 1'b0})
		else $error("sqrt remainder out of range");
`endif

endmodule

FILE: src/svrgb_div.sv
// Pipelined restoring divider for both colour components, 8 quotient bits.
module svrgb_div
	import svrgb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_in,
	input  logic [DIVD_W-1:0] dx_in,
	input  logic [DIVD_W-1:0] dy_in,
	input  logic [DIVS_W-1:0] dv_in,
	input  tag_t              tag_in,
	output logic              valid_out,
	output byte_t             qx_out,
	output byte_t             qy_out,
	output tag_t              tag_out
);

	logic              v_s  [0:QUO_W];
	logic [DIVD_W-1:0] rx_s [0:QUO_W];
	logic [DIVD_W-1:0] ry_s [0:QUO_W];
	logic [DIVS_W-1:0] dv_s [0:QUO_W];
	byte_t             qx_s [0:QUO_W];
	byte_t             qy_s [0:QUO_W];
	tag_t              tag_s[0:QUO_W];

	assign v_s[0]   = valid_in;
	assign rx_s[0]  = dx_in;
	assign ry_s[0]  = dy_in;
	assign dv_s[0]  = dv_in;
	assign qx_s[0]  = '0;
	assign qy_s[0]  = '0;
	assign tag_s[0] = tag_in;

	for (genvar j = 0; j < QUO_W; j++) begin : g_step
		localparam int unsigned K = QUO_W - 1 - j;
		logic [DIVD_W-1:0] sh;
		logic              tx;
		logic              ty;

		always_comb begin
			sh = {{(DIVD_W-DIVS_W){1'b0}}, dv_s[j]} << K;
			tx = (rx_s[j] >= sh);
			ty = (ry_s[j] >= sh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[j+1]  <= tx ? rx_s[j] - sh : rx_s[j];
				ry_s[j+1]  <= ty ? ry_s[j] - sh : ry_s[j];
				qx_s[j+1]  <= {qx_s[j][QUO_W-2:0], tx};
				qy_s[j+1]  <= {qy_s[j][QUO_W-2:0], ty};
				dv_s[j+1]  <= dv_s[j];
				tag_s[j+1] <= tag_s[j];
			end
		end
	end

	assign valid_out = v_s[QUO_W];
	assign qx_out    = qx_s[QUO_W];
	assign qy_out    = qy_s[QUO_W];
	assign tag_out   = tag_s[QUO_W];

`ifndef NO_ASSERTIONS
	// a proper divisor leaves a remainder below itself
	a_rem_x: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[QUO_W] && !tag_s[QUO_W].too_short
		|-> rx_s[QUO_W] < {{(DIVD_W-DIVS_W){1'b0}}, dv_s[QUO_W]})
		else $error("red remainder not reduced");
	a_rem_y: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[QUO_W] && !tag_s[QUO_W].too_short
		|-> ry_s[QUO_W] < {{(DIVD_W-DIVS_W){1'b0}}, dv_s[QUO_W]})
		else $error("green remainder not reduced");
`endif

endmodule

FILE: src/slope_vector_to_rgb_encode.sv
// Pipeline order: square, sum of squares, square root, scale, divide, output register.
// Throughput: one request per cycle while the output is not stalled; root and divider are unrolled.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (arst_n, asynchronous, active low) clears all valid bits; payload registers are not reset.
module slope_vector_to_rgb_encode
	import svrgb_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 20
)(
	input  logic clk,
	input  logic arst_n,
	svrgb_in_if.sink    in,
	svrgb_out_if.source out
);

	localparam logic [37:0] ONE = 38'(1) << FRAC_BITS;

	logic en;
	assign en       = !out.valid || out.ready;
	assign in.ready = en;

	// stage 1: magnitudes squared
	logic             v_s1;
	logic [SQ_W-1:0]  sqx_s1, sqy_s1;
	vec_t             vec_s1;
	logic [IN_W-1:0]  ax, ay;

	always_comb begin
		ax = in.slope_x[IN_W-1] ? IN_W'(-in.slope_x) : in.slope_x;
		ay = in.slope_y[IN_W-1] ? IN_W'(-in.slope_y) : in.slope_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= ax * ax;
			sqy_s1 <= ay * ay;
			vec_s1 <= '{x: in.slope_x, y: in.slope_y};
		end
	end

	// stage 2: sum of squares
	logic            v_s2;
	logic [SQ_W-1:0] sum_s2;
	vec_t            vec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sqx_s1 + sqy_s1;
			vec_s2 <= vec_s1;
		end
	end

	logic             v_rt;
	logic [LEN_W-1:0] len_rt;
	vec_t             vec_rt;

	svrgb_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s2),
		.rad_in    (sum_s2),
		.vec_in    (vec_s2),
		.valid_out (v_rt),
		.root_out  (len_rt),
		.vec_out   (vec_rt)
	);

	// stage 3: dividends, magnitude, blue level and short test
	logic              v_s3;
	logic [DIVD_W-1:0] dx_s3, dy_s3;
	logic [DIVS_W-1:0] dv_s3;
	tag_t              tag_s3;
	logic [DIVS_W:0]   nx, ny;
	logic [37:0]       p1000, p50, p12750, pb;

	always_comb begin
		nx     = (DIVS_W+1)'($signed(vec_rt.x)) + {2'b00, len_rt};
		ny     = (DIVS_W+1)'($signed(vec_rt.y)) + {2'b00, len_rt};
		p1000  = 38'(len_rt) * 38'd1000;
		p50    = 38'(len_rt) * 38'd50;
		p12750 = 38'(len_rt) * 38'd12750;
		pb     = p12750 >> FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_rt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s3 <= ({8'd0, nx[DIVS_W-1:0]} << 8) - {8'd0, nx[DIVS_W-1:0]};
			dy_s3 <= ({8'd0, ny[DIVS_W-1:0]} << 8) - {8'd0, ny[DIVS_W-1:0]};
			dv_s3 <= {len_rt, 1'b0};
			tag_s3.too_short <= (p1000 < ONE);
			tag_s3.blue      <= (p50 >= ONE) ? 8'd255 : pb[7:0];
		end
	end

	logic  v_dv;
	byte_t qx, qy;
	tag_t  tag_dv;

	svrgb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (v_s3),
		.dx_in     (dx_s3),
		.dy_in     (dy_s3),
		.dv_in     (dv_s3),
		.tag_in    (tag_s3),
		.valid_out (v_dv),
		.qx_out    (qx),
		.qy_out    (qy),
		.tag_out   (tag_dv)
	);

	// output register
	logic  v_q;
	byte_t red_q, green_q, blue_q;
	logic  short_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_q   <= tag_dv.too_short ? 8'd255 : qx;
			green_q <= tag_dv.too_short ? 8'd0 : qy;
			blue_q  <= tag_dv.too_short ? 8'd0 : tag_dv.blue;
			short_q <= tag_dv.too_short;
		end
	end

	assign out.valid     = v_q;
	assign out.red       = red_q;
	assign out.green     = green_q;
	assign out.blue      = blue_q;
	assign out.too_short = short_q;

`ifndef NO_ASSERTIONS
	// a held result blocks new requests
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |-> !in.ready)
		else $error("request taken while output stalled");
	// an item in the output register was at the divider output in the previous cycle
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_q) |-> $past(v_dv))
		else $error("output valid without a source");
	// short vectors carry zero blue and full red
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && short_q |-> blue_q == 8'd0 && red_q == 8'd255)
		else $error("short vector encoded wrongly");
`endif

endmodule

FILE: test/testbench.sv
// Testbench for the slope vector to RGB encoder: scoreboard, stimulus and checks.
module testbench;
	import svrgb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAC = 20;
	localparam int unsigned LATENCY = 36;
	localparam int unsigned WATCHDOG = 5000;

	typedef struct packed {
		byte_t red;
		byte_t green;
		byte_t blue;
		logic  too_short;
	} pixel_t;

	// floor square root of a 48-bit value, bit by bit
	function automatic logic [23:0] root48(logic [47:0] v);
		logic [23:0] r;
		logic [23:0] t;
		r = '0;
		for (int b = 23; b >= 0; b--) begin
			t = r | (24'd1 << b);
			if ({24'd0, t} * {24'd0, t} <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic byte_t encode_axis(logic signed [23:0] c, logic [23:0] len);
		longint num;
		longint q;
		num = longint'(c) + longint'(len);
		q = (255 * num) / (2 * longint'(len));
		return q > 255 ? 8'd255 : byte_t'(q);
	endfunction

	function automatic pixel_t encode_pixel(logic signed [23:0] x, logic signed [23:0] y);
		pixel_t p;
		longint ax;
		longint ay;
		logic [23:0] len;
		longint one;
		ax = x < 0 ? -longint'(x) : longint'(x);
		ay = y < 0 ? -longint'(y) : longint'(y);
		len = root48(48'(ax * ax + ay * ay));
		one = longint'(1) << FRAC;
		if (longint'(len) * 1000 < one) begin
			p = '{8'd255, 8'd0, 8'd0, 1'b1};
		end else begin
			p.red = encode_axis(x, len);
			p.green = encode_axis(y, len);
			if (longint'(len) * 50 >= one)
				p.blue = 8'd255;
			else
				p.blue = byte_t'((longint'(255 * 50) * len) >> FRAC);
			p.too_short = 1'b0;
		end
		return p;
	endfunction

	class pixel_board;
		pixel_t pending[$];
		int errors;
		int checked;

		function void note_request(logic signed [23:0] x, logic signed [23:0] y);
			pending.push_back(encode_pixel(x, y));
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (pending.size() == 0) begin
				$display("%0t unexpected pixel %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.red !== want.red) begin
				$display("%0t red: expected %0d actual %0d", $time, want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$display("%0t green: expected %0d actual %0d", $time, want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$display("%0t blue: expected %0d actual %0d", $time, want.blue, got.blue);
				errors++;
			end
			if (got.too_short !== want.too_short) begin
				$display("%0t too_short: expected %0b actual %0b", $time,
					want.too_short, got.too_short);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int send_idle;
	int recv_idle;
	int quiet;
	int n_short;
	pixel_board board;

	svrgb_in_if in_ch();
	svrgb_out_if out_ch();

	slope_vector_to_rgb_encode #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .out(out_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.slope_x = '0;
		in_ch.slope_y = '0;
		out_ch.ready = 1'b0;
		send_idle = 24;
		recv_idle = 88;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				board.check_pixel('{out_ch.red, out_ch.green, out_ch.blue, out_ch.too_short});
				if (out_ch.too_short)
					n_short++;
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog on cycles without any handshake on either channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("watchdog expired");
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_vector(logic signed [23:0] x, logic signed [23:0] y);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.slope_x <= x;
		in_ch.slope_y <= y;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		board.note_request(x, y);
	endtask

	task automatic send_random();
		logic signed [23:0] x;
		logic signed [23:0] y;
		case ($urandom_range(3))
			0: begin
				x = 24'($urandom);
				y = 24'($urandom);
			end
			1: begin
				// around the short threshold
				x = 24'($signed(24'($urandom_range(1100))) * ($urandom_range(1) ? 1 : -1));
				y = 24'($signed(24'($urandom_range(1100))) * ($urandom_range(1) ? 1 : -1));
			end
			2: begin
				// below the blue saturation point
				x = $signed(24'($urandom_range(25000))) - 24'sd12500;
				y = $signed(24'($urandom_range(25000))) - 24'sd12500;
			end
			default: begin
				x = $signed(24'($urandom_range(1 << 21))) - 24'sd1048576;
				y = $signed(24'($urandom_range(1 << 21))) - 24'sd1048576;
			end
		endcase
		send_vector(x, y);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		send_vector(24'sd0, 24'sd0);
		send_vector(24'sd1048, 24'sd0);
		send_vector(24'sd1049, 24'sd0);
		send_vector(-24'sd1049, 24'sd0);
		send_vector(24'sd0, -24'sd1049);
		send_vector(24'sd740, 24'sd740);
		send_vector(24'sd741, -24'sd741);
		send_vector(24'sd20971, 24'sd0);
		send_vector(24'sd20972, 24'sd0);
		send_vector(24'sd8388607, 24'sd8388607);
		send_vector(-24'sd8388608, -24'sd8388608);
		send_vector(-24'sd8388608, 24'sd8388607);
		send_vector(24'sd8388607, 24'sd0);
		send_vector(-24'sd8388608, 24'sd0);
		send_vector(24'sd0, 24'sd8388607);
		send_vector(24'sd0, -24'sd8388608);
		send_vector(24'sd1048576, 24'sd1048576);
		send_vector(-24'sd1048576, 24'sd1048576);
		send_vector(24'sd1, -24'sd1);
		send_vector(24'sd3000, -24'sd4000);
		for (int i = 0; i < 310; i++)
			send_random();
		drain();
		// hold-off: restart only once the pipeline is empty
		send_idle = 88;
		recv_idle = 24;
		for (int i = 0; i < 310; i++)
			send_random();
		drain();
		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < 310; i++)
			send_random();
		drain();
		repeat (LATENCY + 4) @(posedge clk);
		$display("checked %0d pixels, %0d of them too short, under three stall patterns",
			board.checked, n_short);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
